[rtl/hrol_pkg.sv]
// shared types and codes for the ring owner lookup block
package hrol_pkg;

  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 4;
  localparam int SCNT_W   = 4;

  // command codes
  localparam logic [1:0] OP_REGISTER   = 2'd0;
  localparam logic [1:0] OP_SET_ALIVE  = 2'd1;
  localparam logic [1:0] OP_FIND_OWNER = 2'd2;
  localparam logic [1:0] OP_SUCCESSORS = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_DUPLICATE = 2'd3;

  // one ring table entry
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic                alive;
  } entry_t;

endpackage

[rtl/hrol_table_ram.sv]
// ring table storage: one write port, one registered read port
module hrol_table_ram
  import hrol_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  entry_t                     wr_data,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output entry_t                     rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/hash_ring_owner_lookup.sv]
// ring owner lookup: sorted node table with register, alive, owner and successor commands
//
// A command is taken when start is high and busy is low; all in_ fields are
// sampled at that edge. Results come back on the out_ ports, each valid for
// exactly one cycle while out_valid is high; out_last marks the final result
// of a command. The receiver cannot stall, so no result is ever held back.
// The table lives in a single-port-read memory with a registered read port,
// and every command walks it one entry per cycle with reads pipelined.
// Steps: register scans the entries for a duplicate handle and for the
// insert position, answers full when the table is full, else shifts each
// entry from the insert position up by one and writes the new node there
// (nothing moves when it goes at the end); set alive finds the handle and
// rewrites its alive bit (not found when absent); find owner scans for the
// first alive node with a key at or above the lookup key, else takes the
// wrap or miss path to the first alive node; successors locates the handle
// (not found when absent), then walks the ring onward, reporting alive nodes.
// The next command may be taken in the cycle the final result is shown.
// Reset empties the table at once; no clearing pass.
module hash_ring_owner_lookup
  import hrol_pkg::*;
#(
  parameter int MAX_NODES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_opcode,
  input  logic [HANDLE_W-1:0] in_node_handle,
  input  logic [KEY_W-1:0]    in_node_key,
  input  logic [KEY_W-1:0]    in_lookup_key,
  input  logic                in_alive_value,
  input  logic [SCNT_W-1:0]   in_successor_count,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [HANDLE_W-1:0] out_result_handle,
  output logic                out_found,
  output logic                out_changed,
  output logic                out_last
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_NODES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOCATE,
    S_OWNER,
    S_SHIFT,
    S_SUCC
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    iss_r, iss_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]    chk_idx_r, chk_idx_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [HANDLE_W-1:0] h_r, h_nxt;
  logic [KEY_W-1:0]    nkey_r, nkey_nxt;
  logic [KEY_W-1:0]    lkey_r, lkey_nxt;
  logic                alive_r, alive_nxt;
  logic [SCNT_W-1:0]   scnt_r, scnt_nxt;
  logic                ins_vld_r, ins_vld_nxt;
  logic [CNT_W-1:0]    ins_pos_r, ins_pos_nxt;
  logic                fa_vld_r, fa_vld_nxt;
  logic [HANDLE_W-1:0] fa_h_r, fa_h_nxt;
  logic [CNT_W-1:0]    j_r, j_nxt;
  logic [IDX_W-1:0]    w_r, w_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [SCNT_W-1:0]   k_r, k_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [HANDLE_W-1:0] pend_h_r, pend_h_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic                out_found_r, out_found_nxt;
  logic                out_changed_r, out_changed_nxt;
  logic                out_last_r, out_last_nxt;

  // memory port
  logic             we;
  logic [IDX_W-1:0] wa;
  entry_t           wd;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_q;

  hrol_table_ram #(
    .DEPTH(MAX_NODES)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wa),
    .wr_data (wd),
    .rd_addr (rd_addr),
    .rd_data (rd_q)
  );

  // ring successor of the walk pointer and of the located entry
  logic [CNT_W-1:0] w_inc, p_inc;
  logic [IDX_W-1:0] w_wrap, p_wrap;
  assign w_inc  = CNT_W'(w_r) + 1'b1;
  assign p_inc  = CNT_W'(chk_idx_r) + 1'b1;
  assign w_wrap = (w_inc == cnt_r) ? '0 : w_inc[IDX_W-1:0];
  assign p_wrap = (p_inc == cnt_r) ? '0 : p_inc[IDX_W-1:0];

  assign busy = (state_r != S_IDLE);

  // command sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    iss_nxt      = iss_r;
    chk_vld_nxt  = 1'b0;
    chk_idx_nxt  = chk_idx_r;
    op_nxt       = op_r;
    h_nxt        = h_r;
    nkey_nxt     = nkey_r;
    lkey_nxt     = lkey_r;
    alive_nxt    = alive_r;
    scnt_nxt     = scnt_r;
    ins_vld_nxt  = ins_vld_r;
    ins_pos_nxt  = ins_pos_r;
    fa_vld_nxt   = fa_vld_r;
    fa_h_nxt     = fa_h_r;
    j_nxt        = j_r;
    w_nxt        = w_r;
    rem_nxt      = rem_r;
    k_nxt        = k_r;
    pend_vld_nxt = pend_vld_r;
    pend_h_nxt   = pend_h_r;

    out_valid_nxt   = 1'b0;
    out_status_nxt  = ST_OK;
    out_handle_nxt  = '0;
    out_found_nxt   = 1'b0;
    out_changed_nxt = 1'b0;
    out_last_nxt    = 1'b0;

    we      = 1'b0;
    wa      = '0;
    wd      = rd_q;
    rd_addr = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt      = in_opcode;
          h_nxt       = in_node_handle;
          nkey_nxt    = in_node_key;
          lkey_nxt    = in_lookup_key;
          alive_nxt   = in_alive_value;
          scnt_nxt    = in_successor_count;
          iss_nxt     = '0;
          ins_vld_nxt = 1'b0;
          fa_vld_nxt  = 1'b0;
          state_nxt   = (in_opcode == OP_FIND_OWNER) ? S_OWNER : S_LOCATE;
        end
      end

      S_LOCATE: begin
        // pipelined read of the next entry
        if (iss_r < cnt_r) begin
          rd_addr     = iss_r[IDX_W-1:0];
          chk_idx_nxt = iss_r[IDX_W-1:0];
          chk_vld_nxt = 1'b1;
          iss_nxt     = iss_r + 1'b1;
        end
        if (chk_vld_r && rd_q.handle == h_r) begin
          chk_vld_nxt = 1'b0;
          state_nxt   = S_IDLE;
          unique case (op_r)
            OP_REGISTER: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_DUPLICATE;
              out_last_nxt   = 1'b1;
            end
            OP_SET_ALIVE: begin
              we              = 1'b1;
              wa              = chk_idx_r;
              wd              = '{key: rd_q.key, handle: rd_q.handle, alive: alive_r};
              out_valid_nxt   = 1'b1;
              out_handle_nxt  = h_r;
              out_found_nxt   = 1'b1;
              out_changed_nxt = (rd_q.alive != alive_r);
              out_last_nxt    = 1'b1;
            end
            OP_SUCCESSORS: begin
              w_nxt        = p_wrap;
              rem_nxt      = cnt_r - 1'b1;
              k_nxt        = '0;
              pend_vld_nxt = 1'b0;
              state_nxt    = S_SUCC;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_NOT_FOUND;
              out_last_nxt   = 1'b1;
            end
          endcase
        end else begin
          // insert position: first entry with a greater key
          if (chk_vld_r && op_r == OP_REGISTER && !ins_vld_r && rd_q.key > nkey_r) begin
            ins_vld_nxt = 1'b1;
            ins_pos_nxt = CNT_W'(chk_idx_r);
          end
          if (!chk_vld_r && iss_r == cnt_r) begin
            if (op_r == OP_REGISTER && cnt_r != FULL_CNT) begin
              j_nxt     = cnt_r;
              state_nxt = S_SHIFT;
              if (!ins_vld_r) begin
                ins_pos_nxt = cnt_r;
              end
            end else begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = (op_r == OP_REGISTER) ? ST_FULL : ST_NOT_FOUND;
              out_last_nxt   = 1'b1;
              state_nxt      = S_IDLE;
            end
          end
        end
      end

      S_OWNER: begin
        if (iss_r < cnt_r) begin
          rd_addr     = iss_r[IDX_W-1:0];
          chk_idx_nxt = iss_r[IDX_W-1:0];
          chk_vld_nxt = 1'b1;
          iss_nxt     = iss_r + 1'b1;
        end
        if (chk_vld_r && rd_q.alive && rd_q.key >= lkey_r) begin
          chk_vld_nxt    = 1'b0;
          out_valid_nxt  = 1'b1;
          out_handle_nxt = rd_q.handle;
          out_found_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          // remember the first alive node for the wrap case
          if (chk_vld_r && rd_q.alive && !fa_vld_r) begin
            fa_vld_nxt = 1'b1;
            fa_h_nxt   = rd_q.handle;
          end
          if (!chk_vld_r && iss_r == cnt_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = fa_vld_r ? ST_OK : ST_NOT_FOUND;
            out_handle_nxt = fa_vld_r ? fa_h_r : '0;
            out_found_nxt  = fa_vld_r;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end

      S_SHIFT: begin
        // move the entry read last cycle up by one
        if (chk_vld_r) begin
          we = 1'b1;
          wa = chk_idx_r + 1'b1;
          wd = rd_q;
        end
        if (j_r > ins_pos_r) begin
          rd_addr     = IDX_W'(j_r - 1'b1);
          chk_idx_nxt = IDX_W'(j_r - 1'b1);
          chk_vld_nxt = 1'b1;
          j_nxt       = j_r - 1'b1;
        end else if (!chk_vld_r) begin
          we            = 1'b1;
          wa            = IDX_W'(ins_pos_r);
          wd            = '{key: nkey_r, handle: h_r, alive: 1'b1};
          cnt_nxt       = cnt_r + 1'b1;
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_SUCC: begin
        if (k_r == scnt_r || (rem_r == '0 && !chk_vld_r)) begin
          // flush the held successor as the final transfer
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_vld_r ? ST_OK : ST_NOT_FOUND;
          out_handle_nxt = pend_vld_r ? pend_h_r : '0;
          out_found_nxt  = pend_vld_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          if (rem_r != '0) begin
            rd_addr     = w_r;
            chk_idx_nxt = w_r;
            chk_vld_nxt = 1'b1;
            w_nxt       = w_wrap;
            rem_nxt     = rem_r - 1'b1;
          end
          // hold each alive successor until the next one arrives, to know which is last
          if (chk_vld_r && rd_q.alive) begin
            if (pend_vld_r) begin
              out_valid_nxt  = 1'b1;
              out_handle_nxt = pend_h_r;
              out_found_nxt  = 1'b1;
            end
            pend_vld_nxt = 1'b1;
            pend_h_nxt   = rd_q.handle;
            k_nxt        = k_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    iss_r         <= iss_nxt;
    chk_idx_r     <= chk_idx_nxt;
    op_r          <= op_nxt;
    h_r           <= h_nxt;
    nkey_r        <= nkey_nxt;
    lkey_r        <= lkey_nxt;
    alive_r       <= alive_nxt;
    scnt_r        <= scnt_nxt;
    ins_vld_r     <= ins_vld_nxt;
    ins_pos_r     <= ins_pos_nxt;
    fa_vld_r      <= fa_vld_nxt;
    fa_h_r        <= fa_h_nxt;
    j_r           <= j_nxt;
    w_r           <= w_nxt;
    rem_r         <= rem_nxt;
    k_r           <= k_nxt;
    pend_vld_r    <= pend_vld_nxt;
    pend_h_r      <= pend_h_nxt;
    out_status_r  <= out_status_nxt;
    out_handle_r  <= out_handle_nxt;
    out_found_r   <= out_found_nxt;
    out_changed_r <= out_changed_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_handle = out_handle_r;
  assign out_found         = out_found_r;
  assign out_changed       = out_changed_r;
  assign out_last          = out_last_r;

  // node count stays within the table
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("node count beyond table size");

  // the count only grows by one, together with a successful register transfer
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && cnt_r != $past(cnt_r)) |->
      (cnt_r == $past(cnt_r) + 1'b1 && out_valid && out_status == ST_OK))
    else $error("node count changed without a register result");

  // no result in the cycle after a command is taken
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result right after command transfer");

  // non-final results only come while the walk is still running
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("non-final result with block idle");

  // a found node always carries ok status
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> out_status == ST_OK)
    else $error("found result with error status");

endmodule
